FILE: hdl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rdte_pkg.sv
package rdte_pkg;

	localparam int MAX_TEXT = 32;
	localparam int TEXT_AW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int LEN_W    = 6;
	localparam int IDX_W    = 6;
	localparam int CHAR_W   = 7;

	localparam logic [1:0] OP_POLL  = 2'd0;
	localparam logic [1:0] OP_BEGIN = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic MODE_LETTER = 1'b0;
	localparam logic MODE_SYMBOL = 1'b1;

	localparam logic [IDX_W-1:0] ALNUM_LAST      = 6'd39;
	localparam logic [IDX_W-1:0] SYMBOL_LAST     = 6'd24;
	localparam logic [IDX_W-1:0] ALNUM_DIGIT_POS = 6'd26;
	localparam logic [IDX_W-1:0] ALNUM_SHIFT_POS = 6'd36;
	localparam logic [IDX_W-1:0] ALNUM_DEL_POS   = 6'd37;
	localparam logic [IDX_W-1:0] ALNUM_SYM_POS   = 6'd38;
	localparam logic [IDX_W-1:0] ALNUM_OK_POS    = 6'd39;
	localparam logic [IDX_W-1:0] SYMBOL_ABC_POS  = 6'd22;
	localparam logic [IDX_W-1:0] SYMBOL_DEL_POS  = 6'd23;
	localparam logic [IDX_W-1:0] SYMBOL_OK_POS   = 6'd24;

	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;

	function automatic logic [CHAR_W-1:0] symbol_char(input logic [IDX_W-1:0] pos);
		logic [CHAR_W-1:0] c;
		case (pos)
			6'd0:    c = 7'h21; // !
			6'd1:    c = 7'h40; // @
			6'd2:    c = 7'h23; // #
			6'd3:    c = 7'h24; // $
			6'd4:    c = 7'h25; // %
			6'd5:    c = 7'h5e; // ^
			6'd6:    c = 7'h26; // &
			6'd7:    c = 7'h2a; // *
			6'd8:    c = 7'h28; // (
			6'd9:    c = 7'h29; // )
			6'd10:   c = 7'h2d; // -
			6'd11:   c = 7'h5f; // _
			6'd12:   c = 7'h2b; // +
			6'd13:   c = 7'h3d; // =
			6'd14:   c = 7'h2e; // .
			6'd15:   c = 7'h2c; // ,
			6'd16:   c = 7'h3f; // ?
			6'd17:   c = 7'h2f; // /
			6'd18:   c = 7'h3a; // :
			6'd19:   c = 7'h3b; // ;
			6'd20:   c = 7'h27; // quote
			6'd21:   c = 7'h22; // double quote
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

	// Character of a ring entry, zero for function entries.
	function automatic logic [CHAR_W-1:0] entry_char(input logic mode, input logic caps,
			input logic [IDX_W-1:0] pos);
		logic [CHAR_W-1:0] c;
		c = CHAR_NONE;
		if (mode == MODE_SYMBOL) begin
			c = symbol_char(pos);
		end else if (pos < ALNUM_DIGIT_POS) begin
			c = (caps ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(pos);
		end else if (pos < ALNUM_SHIFT_POS) begin
			c = CHAR_ZERO + CHAR_W'(pos - ALNUM_DIGIT_POS);
		end
		return c;
	endfunction

endpackage

FILE: hdl/rdte_ram.sv
module rdte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/rotary_dial_text_entry_top.sv
// Knob-driven character picker. One item is taken every cycle unless in_stall is
// high: begin clears the text and caps and activates the picker, poll steps the
// ring position by the knob turn and acts on a press (shift, delete, ring switch,
// OK, append), read returns a stored character or 0 at or past the text length.
// Each result passes the middle stage and the output register; the text lives in
// a 7-bit wide single-port-write RAM with a registered read, and a read item's
// character is taken from that RAM's output register. Items never collide on one
// entry in the same cycle, so no forwarding is needed. The output register and
// the middle stage let the block take one more item while a result waits.
module rotary_dial_text_entry_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic signed [1:0]                   turn,
	input  logic                                pressed,
	input  logic [4:0]                          read_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                is_active,
	output logic                                finished,
	output logic                                ring_mode,
	output logic                                caps,
	output logic [rdte_pkg::IDX_W-1:0]          selected_index,
	output logic [rdte_pkg::CHAR_W-1:0]         selected_char,
	output logic [rdte_pkg::LEN_W-1:0]          text_length,
	output logic [rdte_pkg::CHAR_W-1:0]         read_char
);
	import rdte_pkg::*;

	`include "assert_macros.svh"

	logic               accept;
	logic               adv_s1;

	logic               mode_q, caps_q, active_q;
	logic [IDX_W-1:0]   idx_q;
	logic [LEN_W-1:0]   len_q;

	logic               mode_d, caps_d, active_d, fin_d;
	logic [IDX_W-1:0]   idx_d, pos, last;
	logic [LEN_W-1:0]   len_d;
	logic               wr_en;
	logic [CHAR_W-1:0]  wr_char;
	logic               rd_en, rd_hit;
	logic [CHAR_W-1:0]  rd_data;

	logic               valid_s1, active_s1, fin_s1, mode_s1, caps_s1, rd_hit_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [CHAR_W-1:0]  sel_s1;
	logic [LEN_W-1:0]   len_s1;

	logic               out_valid_q, active_s2, fin_s2, mode_s2, caps_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [CHAR_W-1:0]  sel_s2, rchar_s2;
	logic [LEN_W-1:0]   len_s2;

	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	assign rd_hit = ({1'b0, read_index} < len_q);
	assign rd_en  = accept && (op == OP_READ);

	always_comb begin
		mode_d   = mode_q;
		caps_d   = caps_q;
		active_d = active_q;
		idx_d    = idx_q;
		len_d    = len_q;
		fin_d    = 1'b0;
		wr_en    = 1'b0;
		last     = (mode_q == MODE_SYMBOL) ? SYMBOL_LAST : ALNUM_LAST;
		pos      = idx_q;
		wr_char  = CHAR_NONE;
		if (op == OP_BEGIN) begin
			len_d    = '0;
			mode_d   = MODE_LETTER;
			idx_d    = '0;
			caps_d   = 1'b0;
			active_d = 1'b1;
		end else if (op == OP_POLL && active_q) begin
			// step the ring, wrapping at both ends
			if (turn == 2'sd1) begin
				pos = (idx_q == last) ? '0 : idx_q + 1'b1;
			end else if (turn[1]) begin
				pos = (idx_q == '0) ? last : idx_q - 1'b1;
			end
			idx_d   = pos;
			wr_char = entry_char(mode_q, caps_q, pos);
			if (pressed) begin
				if (mode_q == MODE_LETTER && pos == ALNUM_SHIFT_POS) begin
					caps_d = !caps_q;
				end else if ((mode_q == MODE_LETTER && pos == ALNUM_DEL_POS) ||
						(mode_q == MODE_SYMBOL && pos == SYMBOL_DEL_POS)) begin
					if (len_q != '0) begin
						len_d = len_q - 1'b1;
					end
				end else if (mode_q == MODE_LETTER && pos == ALNUM_SYM_POS) begin
					mode_d = MODE_SYMBOL;
					idx_d  = '0;
				end else if (mode_q == MODE_SYMBOL && pos == SYMBOL_ABC_POS) begin
					mode_d = MODE_LETTER;
					idx_d  = '0;
				end else if ((mode_q == MODE_LETTER && pos == ALNUM_OK_POS) ||
						(mode_q == MODE_SYMBOL && pos == SYMBOL_OK_POS)) begin
					active_d = 1'b0;
					fin_d    = 1'b1;
				end else if (len_q < LEN_W'(MAX_TEXT)) begin
					wr_en = 1'b1;
					len_d = len_q + 1'b1;
				end
			end
		end
	end

	rdte_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_TEXT),
		.AW    (TEXT_AW)
	) u_text (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (TEXT_AW'(len_q)),
		.wdata (wr_char),
		.re    (rd_en),
		.raddr (TEXT_AW'(read_index)),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LETTER;
			caps_q   <= 1'b0;
			active_q <= 1'b0;
			idx_q    <= '0;
			len_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			caps_q   <= caps_d;
			active_q <= active_d;
			idx_q    <= idx_d;
			len_q    <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			active_s1 <= active_d;
			fin_s1    <= fin_d;
			mode_s1   <= mode_d;
			caps_s1   <= caps_d;
			idx_s1    <= idx_d;
			sel_s1    <= entry_char(mode_d, caps_d, idx_d);
			len_s1    <= len_d;
			rd_hit_s1 <= rd_en && rd_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			active_s2 <= active_s1;
			fin_s2    <= fin_s1;
			mode_s2   <= mode_s1;
			caps_s2   <= caps_s1;
			idx_s2    <= idx_s1;
			sel_s2    <= sel_s1;
			len_s2    <= len_s1;
			rchar_s2  <= rd_hit_s1 ? rd_data : CHAR_NONE;
		end
	end

	assign out_valid      = out_valid_q;
	assign is_active      = active_s2;
	assign finished       = fin_s2;
	assign ring_mode      = mode_s2;
	assign caps           = caps_s2;
	assign selected_index = idx_s2;
	assign selected_char  = sel_s2;
	assign text_length    = len_s2;
	assign read_char      = rchar_s2;

	`ASSERT_ALWAYS(a_idx_in_ring, clk, arst_n, (mode_q == MODE_SYMBOL) ? (idx_q <= SYMBOL_LAST) : (idx_q <= ALNUM_LAST), "ring position off the ring")
	`ASSERT_ALWAYS(a_len_bound, clk, arst_n, len_q <= LEN_W'(MAX_TEXT), "text length past capacity")
	`ASSERT_ALWAYS(a_stall_cause, clk, arst_n, !in_stall || (valid_s1 && out_valid_q), "input stalled with room in the pipeline")
	`ASSERT_ALWAYS(a_fin_ends, clk, arst_n, !(valid_s1 && fin_s1) || !active_s1, "finished while still active")
	`ASSERT_NEXT(a_begin_clears, clk, arst_n, accept && op == OP_BEGIN, active_q && len_q == '0 && idx_q == '0 && !caps_q, "begin did not reset the picker")

endmodule
